// ----- src/pkpt_pkg.sv -----
// package: shared constants, codes and record types for the probe table
`timescale 1ns / 1ps
`default_nettype none
package pkpt_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_PROBE_LIMIT = 8;

  localparam int OP_W    = 2;
  localparam int KEY_W   = 64;
  localparam int KIND_W  = 2;
  localparam int NAMES_W = 32;
  localparam int DIM_W   = 16;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 11;
  localparam int CAP_W   = 4;

  localparam int CAP_LOG2_MIN   = 4;
  localparam int CAP_LOG2_MAX   = 10;
  localparam int CAP_LOG2_RESET = 4;

  localparam logic [31:0] HASH_MULT = 32'h7feb352d;
  localparam int HASH_SHIFT_A = 16;
  localparam int HASH_SHIFT_B = 15;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;

  localparam logic [STAT_W-1:0] ST_NEW     = 3'd0;
  localparam logic [STAT_W-1:0] ST_UPDATED = 3'd1;
  localparam logic [STAT_W-1:0] ST_SKIPPED = 3'd2;
  localparam logic [STAT_W-1:0] ST_DROPPED = 3'd3;
  localparam logic [STAT_W-1:0] ST_HIT     = 3'd4;
  localparam logic [STAT_W-1:0] ST_MISS    = 3'd5;
  localparam logic [STAT_W-1:0] ST_CLEARED = 3'd6;

  typedef enum logic [4:0] {
    S_SWEEP = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HOME  = 5'b00100,
    S_PROBE = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [NAMES_W-1:0] names;
    logic [KIND_W-1:0]  kind;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
  } rec_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [KIND_W-1:0]  kind;
    logic [NAMES_W-1:0] names;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [COUNT_W-1:0] count;
  } res_t;

endpackage
`default_nettype wire

// ----- src/pkpt_if.sv -----
// interfaces: input, result and configuration channels of the probe table
`timescale 1ns / 1ps
`default_nettype none
interface pkpt_in_if import pkpt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [KEY_W-1:0]   key;
  logic [KIND_W-1:0]  container_kind;
  logic [NAMES_W-1:0] name_mask;
  logic [DIM_W-1:0]   box_width;
  logic [DIM_W-1:0]   box_height;
  logic [DIM_W-1:0]   pad_horizontal;
  logic [DIM_W-1:0]   pad_vertical;
  modport source (output valid, operation, key, container_kind, name_mask, box_width,
                  box_height, pad_horizontal, pad_vertical, input ready);
  modport sink (input valid, operation, key, container_kind, name_mask, box_width,
                box_height, pad_horizontal, pad_vertical, output ready);
endinterface

interface pkpt_out_if import pkpt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [KIND_W-1:0]  found_kind;
  logic [NAMES_W-1:0] found_names;
  logic [DIM_W-1:0]   content_w;
  logic [DIM_W-1:0]   content_h;
  logic [COUNT_W-1:0] entry_count;
  modport source (output valid, status, found_kind, found_names, content_w, content_h,
                  entry_count, input ready);
  modport sink (input valid, status, found_kind, found_names, content_w, content_h,
                entry_count, output ready);
endinterface

interface pkpt_cfg_if import pkpt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- src/pointer_keyed_probe_table_core.sv -----
// Probe table core: one item at a time. Insert and lookup go from accept through the
// registered hash multiply (S_HOME), then one slot read from the slot ram per probe
// (S_PROBE, 1..PROBE_LIMIT probes), then S_DONE, which loads the result register.
// Skipped inserts and zero-key lookups go straight to S_DONE. A clear, a capacity write and
// reset each run a pass over all TABLE_DEPTH slots that empties every slot; input is not
// taken during that pass, while a waiting result can still be drained. The result sits
// in an output register, so the next item may be accepted before it is taken.
`timescale 1ns / 1ps
`default_nettype none
module pointer_keyed_probe_table_core import pkpt_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int PROBE_LIMIT = DEF_PROBE_LIMIT
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  pkpt_in_if.sink     in_chan,
  pkpt_out_if.source  out_chan,
  pkpt_cfg_if.sink    cfg_chan
);

  localparam int ADDR_W     = $clog2(TABLE_DEPTH);
  localparam int DEPTH_LOG2 = $clog2(TABLE_DEPTH + 1) - 1;
  localparam int PRB_W      = $clog2(PROBE_LIMIT + 1);
  localparam logic [ADDR_W-1:0] LAST_SLOT  = ADDR_W'(TABLE_DEPTH - 1);
  localparam logic [PRB_W-1:0]  LAST_PROBE = PRB_W'(PROBE_LIMIT - 1);

  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  sweep_r, sweep_nxt;
  logic [CAP_W-1:0]   cap_r, cap_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  res_t               out_r, out_nxt;
  res_t               res_r, res_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [NAMES_W-1:0] names_r, names_nxt;
  logic [DIM_W-1:0]   w_r, w_nxt;
  logic [DIM_W-1:0]   h_r, h_nxt;
  logic [ADDR_W-1:0]  slot_r, slot_nxt;
  logic [PRB_W-1:0]   probe_r, probe_nxt;

  logic               in_ready;
  logic               in_acc;
  logic               cfg_acc;
  logic [CAP_W-1:0]   lg;
  logic [ADDR_W-1:0]  mask;
  logic [ADDR_W-1:0]  home;
  logic [ADDR_W-1:0]  next_slot;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ADDR_W-1:0]  ram_raddr;
  rec_t               wr_rec;
  rec_t               rd_rec;
  logic [$bits(rec_t)-1:0] ram_rdata;
  logic               slot_empty;
  logic               key_match;
  logic               last_probe;
  logic [COUNT_W-1:0] count_inc;
  logic [DIM_W-1:0]   clamp_w;
  logic [DIM_W-1:0]   clamp_h;

  pkpt_hash #(.ADDR_W(ADDR_W)) u_hash (
    .clk   (clk),
    .start (in_acc),
    .key   (in_chan.key),
    .home  (home)
  );

  pkpt_ram #(.WIDTH($bits(rec_t)), .DEPTH(TABLE_DEPTH)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_rec),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_chan.ready = 1'b1;
  assign cfg_acc        = cfg_chan.valid;
  assign in_ready       = (state_r == S_IDLE) && !cfg_chan.valid;
  assign in_chan.ready  = in_ready;
  assign in_acc         = in_chan.valid && in_ready;

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_r.status;
  assign out_chan.found_kind  = out_r.kind;
  assign out_chan.found_names = out_r.names;
  assign out_chan.content_w   = out_r.width;
  assign out_chan.content_h   = out_r.height;
  assign out_chan.entry_count = out_r.count;

  // effective capacity: clamp to the legal range, then to what the ram holds
  always_comb begin
    lg = cap_r;
    if (lg < CAP_W'(CAP_LOG2_MIN)) begin
      lg = CAP_W'(CAP_LOG2_MIN);
    end
    if (lg > CAP_W'(CAP_LOG2_MAX)) begin
      lg = CAP_W'(CAP_LOG2_MAX);
    end
    if (lg > CAP_W'(DEPTH_LOG2)) begin
      lg = CAP_W'(DEPTH_LOG2);
    end
    mask = ~({ADDR_W{1'b1}} << lg);
  end

  assign rd_rec     = rec_t'(ram_rdata);
  assign slot_empty = !rd_rec.valid;
  assign key_match  = rd_rec.valid && (rd_rec.key == key_r);
  assign last_probe = (probe_r == LAST_PROBE);
  assign next_slot  = (slot_r + ADDR_W'(1)) & mask;
  assign count_inc  = count_r + COUNT_W'(1);
  assign clamp_w    = (in_chan.box_width > in_chan.pad_horizontal) ?
                      in_chan.box_width - in_chan.pad_horizontal : '0;
  assign clamp_h    = (in_chan.box_height > in_chan.pad_vertical) ?
                      in_chan.box_height - in_chan.pad_vertical : '0;

  always_comb begin
    state_nxt     = state_r;
    sweep_nxt     = sweep_r;
    cap_nxt       = cap_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_nxt       = out_r;
    res_nxt       = res_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    kind_nxt      = kind_r;
    names_nxt     = names_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    slot_nxt      = slot_r;
    probe_nxt     = probe_r;
    ram_we        = 1'b0;
    ram_waddr     = slot_r;
    ram_raddr     = slot_r;
    wr_rec        = '{valid: 1'b1, key: key_r, names: names_r, kind: kind_r,
                      width: w_r, height: h_r};

    unique case (state_r)
      S_SWEEP: begin
        ram_we       = 1'b1;
        ram_waddr    = sweep_r;
        wr_rec       = '0;
        sweep_nxt    = sweep_r + ADDR_W'(1);
        if (sweep_r == LAST_SLOT) begin
          sweep_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_chan.operation;
          key_nxt   = in_chan.key;
          kind_nxt  = in_chan.container_kind;
          names_nxt = in_chan.name_mask;
          w_nxt     = clamp_w;
          h_nxt     = clamp_h;
          res_nxt   = '0;
          res_nxt.count = count_r;
          unique case (in_chan.operation)
            OP_CLEAR: begin
              count_nxt      = '0;
              res_nxt.status = ST_CLEARED;
              res_nxt.count  = '0;
              state_nxt      = S_DONE;
            end
            OP_INSERT: begin
              if (in_chan.key == '0 ||
                  (in_chan.container_kind == KIND_NONE && in_chan.name_mask == '0)) begin
                res_nxt.status = ST_SKIPPED;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_HOME;
              end
            end
            default: begin
              // lookup, and the unused operation code which behaves as one
              if (in_chan.key == '0) begin
                res_nxt.status = ST_MISS;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_HOME;
              end
            end
          endcase
        end
      end
      S_HOME: begin
        ram_raddr = home & mask;
        slot_nxt  = home & mask;
        probe_nxt = '0;
        state_nxt = S_PROBE;
      end
      S_PROBE: begin
        // read data belongs to slot_r; the next slot is fetched meanwhile
        ram_raddr = next_slot;
        slot_nxt  = next_slot;
        probe_nxt = probe_r + PRB_W'(1);
        if (op_r == OP_INSERT) begin
          if (slot_empty || key_match) begin
            ram_we    = 1'b1;
            count_nxt = slot_empty ? count_inc : count_r;
            res_nxt   = '{status: slot_empty ? ST_NEW : ST_UPDATED, kind: kind_r,
                          names: names_r, width: w_r, height: h_r,
                          count: slot_empty ? count_inc : count_r};
            state_nxt = S_DONE;
          end else if (last_probe) begin
            res_nxt        = '0;
            res_nxt.status = ST_DROPPED;
            res_nxt.count  = count_r;
            state_nxt      = S_DONE;
          end
        end else begin
          if (key_match) begin
            res_nxt   = '{status: ST_HIT, kind: rd_rec.kind, names: rd_rec.names,
                          width: rd_rec.width, height: rd_rec.height, count: count_r};
            state_nxt = S_DONE;
          end else if (slot_empty || last_probe) begin
            res_nxt        = '0;
            res_nxt.status = ST_MISS;
            res_nxt.count  = count_r;
            state_nxt      = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          sweep_nxt     = '0;
          state_nxt     = (res_r.status == ST_CLEARED) ? S_SWEEP : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_SWEEP;
        sweep_nxt = '0;
      end
    endcase

    // new capacity means a new layout: empty the table
    if (cfg_acc) begin
      cap_nxt   = cfg_chan.data;
      count_nxt = '0;
      sweep_nxt = '0;
      state_nxt = S_SWEEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      sweep_r     <= '0;
      cap_r       <= CAP_W'(CAP_LOG2_RESET);
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      cap_r       <= cap_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r   <= out_nxt;
    res_r   <= res_nxt;
    op_r    <= op_nxt;
    key_r   <= key_nxt;
    kind_r  <= kind_nxt;
    names_r <= names_nxt;
    w_r     <= w_nxt;
    h_r     <= h_nxt;
    slot_r  <= slot_nxt;
    probe_r <= probe_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(TABLE_DEPTH))
    else $error("occupied count exceeds table depth");

  a_sweep_clears: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SWEEP |-> ram_we && !wr_rec.valid)
    else $error("clearing pass did not write an empty slot");

  a_probe_write: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r == S_PROBE) |-> (op_r == OP_INSERT) && wr_rec.valid)
    else $error("slot written by a non-insert item");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("input taken again right after an accept");

  a_probe_limit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PROBE |-> probe_r <= LAST_PROBE)
    else $error("probe count ran past the limit");

  a_cleared_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == ST_CLEARED) |-> out_r.count == '0)
    else $error("clear reported a nonzero count");

endmodule
`default_nettype wire

// ----- src/pkpt_ram.sv -----
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps
`default_nettype none
module pkpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- src/pkpt_hash.sv -----
// key mixer: xorshift, one registered multiply, xorshift, low address bits only
`timescale 1ns / 1ps
`default_nettype none
module pkpt_hash import pkpt_pkg::*; #(
  parameter int ADDR_W = 10
) (
  input  wire logic              clk,
  input  wire logic              start,
  input  wire logic [KEY_W-1:0]  key,
  output logic      [ADDR_W-1:0] home
);

  // only the low bits that can reach the masked home slot are carried
  localparam int HW = ADDR_W + HASH_SHIFT_B;
  localparam logic [HW-1:0] MULT_LO = HW'(HASH_MULT);

  logic [HW-1:0] mixed;
  logic [HW-1:0] prod_r;

  assign mixed = key[HW-1:0] ^ key[HW+HASH_SHIFT_A-1:HASH_SHIFT_A];

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= HW'(mixed * MULT_LO);
    end
  end

  assign home = prod_r[ADDR_W-1:0] ^ prod_r[ADDR_W+HASH_SHIFT_B-1:HASH_SHIFT_B];

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// testbench for the probe table core: directed and random items checked against a local model
`timescale 1ns / 1ps
module tb;
  import pkpt_pkg::*;

  localparam logic [OP_W-1:0]   OP_SPARE    = 2'd3;
  localparam logic [KIND_W-1:0] KIND_INLINE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SIZE   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_THREE  = 2'd3;
  localparam int SLOT_MAX        = DEF_TABLE_DEPTH;
  localparam int ITEMS_PER_PHASE = 135;
  localparam int CROWD_SIZE      = 10;
  localparam int DIRECT_HOME     = 15;
  localparam int SETTLE_CYCLES   = 40;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [KEY_W-1:0]   key;
    logic [KIND_W-1:0]  kind;
    logic [NAMES_W-1:0] names;
    logic [DIM_W-1:0]   bw;
    logic [DIM_W-1:0]   bh;
    logic [DIM_W-1:0]   ph;
    logic [DIM_W-1:0]   pv;
  } item_t;

  typedef enum logic [1:0] {REQ_ITEM, REQ_DRAIN, REQ_CAP} req_kind_t;

  typedef struct {
    req_kind_t        kind;
    item_t            item;
    logic [CAP_W-1:0] cap;
  } req_t;

  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pkpt_in_if  in_if ();
  pkpt_out_if out_if ();
  pkpt_cfg_if cfg_if ();

  pointer_keyed_probe_table_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // local copy of the table
  rec_t             slot_rec [SLOT_MAX];
  logic [CAP_W-1:0] cap_code = CAP_LOG2_RESET;
  int unsigned      filled = 0;

  req_t stim_q [$];
  res_t want_q [$];

  int       fail_count = 0;
  int       results_seen = 0;
  logic     in_took = 1'b0;
  logic     cfg_took = 1'b0;
  logic     drv_in_valid;
  logic     drv_cfg_valid;
  int       gap_left = 0;
  int       burst_left = 1;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic report_fault(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] exp);
    if (got !== exp)
      report_fault($sformatf("result %0d %s: got %0h, want %0h", results_seen, name, got, exp));
  endtask

  function automatic int unsigned slots_for(logic [CAP_W-1:0] code);
    int unsigned lg;
    int unsigned n;
    lg = code;
    if (lg < CAP_LOG2_MIN) lg = CAP_LOG2_MIN;
    if (lg > CAP_LOG2_MAX) lg = CAP_LOG2_MAX;
    n = 1 << lg;
    while (n > DEF_TABLE_DEPTH && n > 1) n = n >> 1;
    return n;
  endfunction

  function automatic logic [KEY_W-1:0] mix64(logic [KEY_W-1:0] x);
    x = x ^ (x >> HASH_SHIFT_A);
    x = x * {32'd0, HASH_MULT};
    x = x ^ (x >> HASH_SHIFT_B);
    return x;
  endfunction

  function automatic void wipe_table();
    foreach (slot_rec[i]) slot_rec[i].valid = 1'b0;
    filled = 0;
  endfunction

  // applies one item to the local table and returns the result it should give
  function automatic res_t probe_step(item_t it);
    res_t             r;
    logic [KEY_W-1:0] h;
    int unsigned      n_slots;
    int unsigned      home;
    int unsigned      s;
    int               hit;
    bit               stop;
    r = '0;
    hit = -1;
    stop = 1'b0;
    n_slots = slots_for(cap_code);
    h = mix64(it.key);
    home = h[9:0] & (n_slots - 1);
    if (it.op == OP_CLEAR) begin
      wipe_table();
      r.status = ST_CLEARED;
    end else if (it.op == OP_INSERT) begin
      if (it.key == '0 || (it.kind == KIND_NONE && it.names == '0)) begin
        r.status = ST_SKIPPED;
      end else begin
        r.status = ST_DROPPED;
        for (int p = 0; p < DEF_PROBE_LIMIT && hit < 0; p++) begin
          s = (home + p) & (n_slots - 1);
          if (!slot_rec[s].valid || slot_rec[s].key == it.key) begin
            if (!slot_rec[s].valid) begin
              filled++;
              r.status = ST_NEW;
            end else begin
              r.status = ST_UPDATED;
            end
            slot_rec[s].valid  = 1'b1;
            slot_rec[s].key    = it.key;
            slot_rec[s].names  = it.names;
            slot_rec[s].kind   = it.kind;
            slot_rec[s].width  = (it.bw > it.ph) ? it.bw - it.ph : '0;
            slot_rec[s].height = (it.bh > it.pv) ? it.bh - it.pv : '0;
            hit = s;
          end
        end
      end
    end else begin
      // lookup, and the spare operation code behaves the same
      r.status = ST_MISS;
      if (it.key != '0) begin
        for (int p = 0; p < DEF_PROBE_LIMIT && hit < 0 && !stop; p++) begin
          s = (home + p) & (n_slots - 1);
          if (!slot_rec[s].valid) begin
            stop = 1'b1;
          end else if (slot_rec[s].key == it.key) begin
            r.status = ST_HIT;
            hit = s;
          end
        end
      end
    end
    if (hit >= 0) begin
      r.kind   = slot_rec[hit].kind;
      r.names  = slot_rec[hit].names;
      r.width  = slot_rec[hit].width;
      r.height = slot_rec[hit].height;
    end
    r.count = COUNT_W'(filled);
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] k;
    k = {$urandom, $urandom};
    if (k == '0) k = 64'd1;
    return k;
  endfunction

  // draws keys until one lands on the given home slot
  function automatic logic [KEY_W-1:0] key_at_home(int unsigned home, int unsigned n_slots);
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] h;
    do begin
      k = {$urandom, $urandom};
      h = mix64(k);
    end while (k == '0 || (h[9:0] & (n_slots - 1)) != home);
    return k;
  endfunction

  task automatic add_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] key, logic [KIND_W-1:0] kind,
                          logic [NAMES_W-1:0] names, logic [DIM_W-1:0] bw,
                          logic [DIM_W-1:0] bh, logic [DIM_W-1:0] ph, logic [DIM_W-1:0] pv);
    req_t rq;
    rq.kind = REQ_ITEM;
    rq.item = '{op: op, key: key, kind: kind, names: names, bw: bw, bh: bh, ph: ph, pv: pv};
    rq.cap  = '0;
    stim_q.push_back(rq);
  endtask

  task automatic add_marker(req_kind_t kind, logic [CAP_W-1:0] cap);
    req_t rq;
    rq.kind = kind;
    rq.item = '0;
    rq.cap  = cap;
    stim_q.push_back(rq);
  endtask

  task automatic add_random_phase(int n_items, int unsigned n_slots);
    logic [KEY_W-1:0]   pool [$];
    logic [KEY_W-1:0]   k;
    logic [KIND_W-1:0]  kind;
    logic [NAMES_W-1:0] names;
    logic [DIM_W-1:0]   bw;
    logic [DIM_W-1:0]   bh;
    logic [DIM_W-1:0]   ph;
    logic [DIM_W-1:0]   pv;
    logic [OP_W-1:0]    look_op;
    int unsigned        crowd_home;
    int                 pool_n;
    int                 pick;
    int                 made;
    crowd_home = $urandom_range(0, n_slots - 1);
    pool_n = (n_slots < 64) ? n_slots + 12 : 40;
    for (int i = 0; i < pool_n; i++) pool.push_back(fresh_key());
    // keys sharing one home slot, so clusters fill and overflow at any capacity
    for (int i = 0; i < CROWD_SIZE; i++) pool.push_back(key_at_home(crowd_home, n_slots));
    made = 0;
    while (made < n_items) begin
      k = pool[$urandom_range(0, pool.size() - 1)];
      kind = $urandom_range(0, 3);
      names = ($urandom_range(0, 3) == 0) ? '0 : $urandom;
      bw = $urandom;
      bh = $urandom;
      ph = $urandom_range(0, 1) ? DIM_W'($urandom) : DIM_W'($urandom_range(0, bw));
      pv = $urandom_range(0, 1) ? DIM_W'($urandom) : DIM_W'($urandom_range(0, bh));
      look_op = ($urandom_range(0, 7) == 0) ? OP_SPARE : OP_LOOKUP;
      pick = $urandom_range(0, 99);
      made++;
      if (pick < 44)
        add_item(OP_INSERT, k, kind, names, bw, bh, ph, pv);
      else if (pick < 72)
        add_item(look_op, k, kind, names, bw, bh, ph, pv);
      else if (pick < 80)
        add_item(look_op, fresh_key(), kind, names, bw, bh, ph, pv);
      else if (pick < 86)
        add_item(OP_INSERT, fresh_key(), kind, names, bw, bh, ph, pv);
      else if (pick < 90)
        add_item(OP_INSERT, k, KIND_NONE, '0, bw, bh, ph, pv);
      else if (pick < 93)
        add_item($urandom_range(0, 1) ? OP_INSERT : look_op, '0, kind, names, bw, bh, ph, pv);
      else if (pick < 95)
        add_item(OP_CLEAR, k, kind, names, bw, bh, ph, pv);
      else if (pick < 97)
        add_item(OP_INSERT, k, KIND_THREE, names, bw, bh, ph, pv);
      else begin
        add_marker(REQ_DRAIN, '0);
        made--;
      end
    end
  endtask

  // sample at the rising edge: check results first, then predict newly taken items
  always @(posedge clk) begin : monitor
    res_t want;
    if (rst_n === 1'b1) begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (want_q.size() == 0) begin
          report_fault($sformatf("result %0d arrived with none expected, status %0d",
                                 results_seen, out_if.status));
        end else begin
          want = want_q.pop_front();
          check_field("status", out_if.status, want.status);
          check_field("found_kind", out_if.found_kind, want.kind);
          check_field("found_names", out_if.found_names, want.names);
          check_field("content_w", out_if.content_w, want.width);
          check_field("content_h", out_if.content_h, want.height);
          check_field("entry_count", out_if.entry_count, want.count);
        end
      end
      if (in_if.valid && in_if.ready)
        want_q.push_back(probe_step('{op: in_if.operation, key: in_if.key,
                                      kind: in_if.container_kind, names: in_if.name_mask,
                                      bw: in_if.box_width, bh: in_if.box_height,
                                      ph: in_if.pad_horizontal, pv: in_if.pad_vertical}));
      if (cfg_if.valid && cfg_if.ready) begin
        // a capacity write also starts over with an empty table
        cap_code = cfg_if.data;
        wipe_table();
      end
    end
    in_took  <= (rst_n === 1'b1) && in_if.valid && in_if.ready;
    cfg_took <= (rst_n === 1'b1) && cfg_if.valid && cfg_if.ready;
  end

  always @(negedge clk) begin : driver
    req_t head;
    if (rst_n === 1'b1) begin
      drv_in_valid  = in_if.valid && !in_took;
      drv_cfg_valid = cfg_if.valid && !cfg_took;
      if (!drv_in_valid && !drv_cfg_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_q.size() != 0) begin
          head = stim_q[0];
          case (head.kind)
            REQ_ITEM: begin
              void'(stim_q.pop_front());
              in_if.operation      <= head.item.op;
              in_if.key            <= head.item.key;
              in_if.container_kind <= head.item.kind;
              in_if.name_mask      <= head.item.names;
              in_if.box_width      <= head.item.bw;
              in_if.box_height     <= head.item.bh;
              in_if.pad_horizontal <= head.item.ph;
              in_if.pad_vertical   <= head.item.pv;
              drv_in_valid = 1'b1;
              burst_left--;
              if (burst_left <= 0) begin
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 8);
                gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                       : $urandom_range(0, 6);
              end
            end
            REQ_DRAIN: begin
              if (want_q.size() == 0) void'(stim_q.pop_front());
            end
            default: begin
              // capacity writes only once every result is back
              if (want_q.size() == 0) begin
                void'(stim_q.pop_front());
                cfg_if.data <= head.cap;
                drv_cfg_valid = 1'b1;
              end
            end
          endcase
        end
      end
      in_if.valid  <= drv_in_valid;
      cfg_if.valid <= drv_cfg_valid;
    end
  end

  always @(negedge clk) begin : receiver
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 96);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:  out_if.ready <= 1'b1;
      RX_LIGHT: out_if.ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: out_if.ready <= ($urandom_range(0, 3) == 0);
      default:  out_if.ready <= ~out_if.ready;
    endcase
  end

  initial begin
    #10_000_000;
    $display("tb failed");
    $finish;
  end

  initial begin : stimulus
    logic [KEY_W-1:0] kmax;
    logic [KEY_W-1:0] crowd [9];
    logic [CAP_W-1:0] cap_plan [8];
    in_if.valid          = 1'b0;
    in_if.operation      = OP_INSERT;
    in_if.key            = '0;
    in_if.container_kind = KIND_NONE;
    in_if.name_mask      = '0;
    in_if.box_width      = '0;
    in_if.box_height     = '0;
    in_if.pad_horizontal = '0;
    in_if.pad_vertical   = '0;
    cfg_if.valid         = 1'b0;
    cfg_if.data          = CAP_LOG2_RESET;
    out_if.ready         = 1'b0;
    wipe_table();

    // directed part at the reset capacity
    kmax = '1;
    add_item(OP_LOOKUP, kmax, KIND_NONE, '0, '0, '0, '0, '0);
    add_item(OP_INSERT, kmax, KIND_SIZE, '1, '1, '1, '0, '0);
    add_item(OP_INSERT, kmax, KIND_INLINE, '0, 16'd5, 16'd100, 16'd9, 16'd100);
    add_item(OP_LOOKUP, kmax, KIND_NONE, '0, '0, '0, '0, '0);
    add_item(OP_INSERT, 64'd1, KIND_NONE, '0, 16'd7, 16'd7, 16'd1, 16'd1);
    add_item(OP_INSERT, '0, KIND_SIZE, 32'hff, 16'd9, 16'd9, '0, '0);
    add_item(OP_LOOKUP, '0, KIND_NONE, '0, '0, '0, '0, '0);
    add_item(OP_INSERT, 64'd2, KIND_THREE, '0, '0, '0, '1, '1);
    add_item(OP_SPARE, 64'd2, KIND_NONE, '0, '0, '0, '0, '0);
    add_item(OP_CLEAR, kmax, KIND_SIZE, '1, '1, '1, '1, '1);
    // nine keys on the last slot: the cluster wraps, eight fit and the ninth drops
    for (int i = 0; i < 9; i++) begin
      crowd[i] = key_at_home(DIRECT_HOME, slots_for(CAP_LOG2_RESET));
      add_item(OP_INSERT, crowd[i], KIND_W'(i % 4), (i % 4 == 1) ? '0 : ($urandom | 32'd1),
               DIM_W'($urandom), DIM_W'($urandom), DIM_W'($urandom), DIM_W'($urandom));
    end
    add_item(OP_LOOKUP, crowd[8], KIND_NONE, '0, '0, '0, '0, '0);
    add_item(OP_LOOKUP, crowd[7], KIND_NONE, '0, '0, '0, '0, '0);
    add_item(OP_INSERT, crowd[0], KIND_SIZE, 32'h8000_0001, 16'd40, 16'd30, 16'd4, 16'd3);
    add_item(OP_LOOKUP, fresh_key(), KIND_NONE, '0, '0, '0, '0, '0);
    add_marker(REQ_DRAIN, '0);

    cap_plan = '{4'd10, 4'd0, 4'd6, 4'd15, 4'd4, 4'd3, 4'd8, 4'd10};
    foreach (cap_plan[i]) begin
      add_marker(REQ_CAP, cap_plan[i]);
      add_random_phase(ITEMS_PER_PHASE, slots_for(cap_plan[i]));
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (stim_q.size() != 0 || in_if.valid || cfg_if.valid || want_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (want_q.size() != 0)
      report_fault($sformatf("%0d results never arrived", want_q.size()));

    if (fail_count == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
